// ----- rtl/core/bmp_pkg.sv -----
// shared types, constants and header byte lookup for the bmp stream encoder
package bmp_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int DIM_W   = 13;  // config register width
  localparam int CNT_W   = 12;  // column and row counters
  localparam int IMG_W   = 26;  // image byte count, below 2^26 at the maximum size
  localparam int POS_W   = 6;   // byte position inside one pixel's run
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [POS_W-1:0] HDR_BYTES      = 6'd54;
  localparam logic [31:0]      INFO_BYTES     = 32'd40;
  localparam logic [31:0]      BITS_PER_PIXEL = 32'd24;
  localparam logic [31:0]      PELS_PER_METER = 32'd2835;
  localparam logic [31:0]      PLANES         = 32'd1;

  // one classified pixel waiting for the byte sequencer
  typedef struct packed {
    logic [23:0]      rgb;
    logic             hdr;
    logic [1:0]       pad;
    logic             eof;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [IMG_W-1:0] img;
  } cmd_t;

  function automatic logic [7:0] le_byte(input logic [31:0] v, input logic [1:0] sel);
    logic [7:0] b;
    b = v[8*sel +: 8];
    return b;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [POS_W-1:0] idx,
                                          input logic [DIM_W-1:0] w,
                                          input logic [DIM_W-1:0] h,
                                          input logic [IMG_W-1:0] img);
    logic [31:0] fsize;
    logic [31:0] img32;
    logic [31:0] w32;
    logic [31:0] h32;
    logic [7:0]  b;
    img32 = {{(32-IMG_W){1'b0}}, img};
    fsize = img32 + {{(32-POS_W){1'b0}}, HDR_BYTES};
    w32   = {{(32-DIM_W){1'b0}}, w};
    h32   = {{(32-DIM_W){1'b0}}, h};
    unique case (idx)
      6'd0:                      b = 8'h42;
      6'd1:                      b = 8'h4d;
      6'd2, 6'd3, 6'd4, 6'd5:     b = le_byte(fsize, 2'(idx - 6'd2));
      6'd10:                     b = le_byte({{(32-POS_W){1'b0}}, HDR_BYTES}, 2'd0);
      6'd14:                     b = le_byte(INFO_BYTES, 2'd0);
      6'd18, 6'd19, 6'd20, 6'd21: b = le_byte(w32, 2'(idx - 6'd18));
      6'd22, 6'd23, 6'd24, 6'd25: b = le_byte(h32, 2'(idx - 6'd22));
      6'd26:                     b = le_byte(PLANES, 2'd0);
      6'd28:                     b = le_byte(BITS_PER_PIXEL, 2'd0);
      6'd34, 6'd35, 6'd36, 6'd37: b = le_byte(img32, 2'(idx - 6'd34));
      6'd38, 6'd39, 6'd40, 6'd41: b = le_byte(PELS_PER_METER, 2'(idx - 6'd38));
      6'd42, 6'd43, 6'd44, 6'd45: b = le_byte(PELS_PER_METER, 2'(idx - 6'd42));
      default:                   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/bmp_stream_if.sv -----
// valid/ready stream interfaces for pixels in and bytes out
interface bmp_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink (input valid, input pixel_word, output ready);
endinterface

interface bmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_image;

  modport source (output valid, output out_byte, output last_of_run, output end_of_image,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input end_of_image,
                output ready);
endinterface

// ----- rtl/core/bmp_front.sv -----
// front end: config registers, row/frame tracking and pixel classification
module bmp_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [bmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmp_pkg::DIM_W-1:0]    cfg_data,
  bmp_pixel_if.sink                    pixel_in,
  input  logic                         full,
  output logic                         push,
  output bmp_pkg::cmd_t                push_data
);

  logic [bmp_pkg::DIM_W-1:0] image_width;
  logic [bmp_pkg::DIM_W-1:0] image_height;
  logic [bmp_pkg::CNT_W-1:0] column_count;
  logic [bmp_pkg::CNT_W-1:0] row_count;
  logic                      header_sent;

  logic [bmp_pkg::DIM_W-1:0] w;
  logic [bmp_pkg::DIM_W-1:0] h;
  logic [1:0]                pad;
  logic [14:0]               line_len;
  logic [27:0]               img_full;
  logic                      col_end;
  logic                      row_end;

  always_comb begin
    if (image_width == '0) begin
      w = 13'd1;
    end else if (image_width > 13'(bmp_pkg::MAX_WIDTH)) begin
      w = 13'(bmp_pkg::MAX_WIDTH);
    end else begin
      w = image_width;
    end
    if (image_height == '0) begin
      h = 13'd1;
    end else if (image_height > 13'(bmp_pkg::MAX_HEIGHT)) begin
      h = 13'(bmp_pkg::MAX_HEIGHT);
    end else begin
      h = image_height;
    end
  end

  // 3w mod 4 equals -w mod 4, so the pad is just w mod 4
  assign pad      = w[1:0];
  assign line_len = {1'b0, w, 1'b0} + {2'b00, w} + {13'd0, pad};
  assign img_full = {13'd0, line_len} * {15'd0, h};

  assign col_end = ({1'b0, column_count} + 13'd1) >= w;
  assign row_end = ({1'b0, row_count} + 13'd1) >= h;

  assign pixel_in.ready = !full;
  assign push           = pixel_in.valid && !full;

  always_comb begin
    push_data.rgb = pixel_in.pixel_word[23:0];
    push_data.hdr = !header_sent;
    push_data.pad = col_end ? pad : 2'd0;
    push_data.eof = col_end && row_end;
    push_data.w   = w;
    push_data.h   = h;
    push_data.img = img_full[bmp_pkg::IMG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bmp_pkg::WIDTH_RESET;
      image_height <= bmp_pkg::HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bmp_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bmp_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      header_sent  <= 1'b0;
    end else if (push) begin
      if (col_end) begin
        column_count <= '0;
        if (row_end) begin
          row_count   <= '0;
          header_sent <= 1'b0;
        end else begin
          row_count   <= row_count + 12'd1;
          header_sent <= 1'b1;
        end
      end else begin
        column_count <= column_count + 12'd1;
        header_sent  <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/bmp_cmd_fifo.sv -----
// two-entry queue of classified pixels between front and back
module bmp_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bmp_pkg::cmd_t push_data,
  input  logic          pop,
  output bmp_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  bmp_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/bmp_back.sv -----
// back end: walks header, pixel and pad bytes into the output register
module bmp_back (
  input  logic          clk,
  input  logic          rst,
  input  bmp_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  bmp_byte_if.source    bytes_out
);

  logic [bmp_pkg::POS_W-1:0] pos;
  logic [bmp_pkg::POS_W-1:0] base;
  logic [bmp_pkg::POS_W-1:0] run_len;
  logic [bmp_pkg::POS_W-1:0] j;
  logic                      emit;
  logic                      last;
  logic [7:0]                byte_next;

  assign base    = head.hdr ? bmp_pkg::HDR_BYTES : 6'd0;
  assign run_len = base + 6'd3 + {4'd0, head.pad};
  assign j       = pos - base;
  assign last    = pos == (run_len - 6'd1);
  assign emit    = !empty && (!bytes_out.valid || bytes_out.ready);
  assign pop     = emit && last;

  always_comb begin
    if (head.hdr && pos < bmp_pkg::HDR_BYTES) begin
      byte_next = bmp_pkg::hdr_byte(pos, head.w, head.h, head.img);
    end else begin
      unique case (j)
        6'd0:    byte_next = head.rgb[7:0];
        6'd1:    byte_next = head.rgb[15:8];
        6'd2:    byte_next = head.rgb[23:16];
        default: byte_next = 8'h00;  // row padding
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos             <= '0;
      bytes_out.valid <= 1'b0;
    end else begin
      if (emit) begin
        pos             <= last ? 6'd0 : pos + 6'd1;
        bytes_out.valid <= 1'b1;
      end else if (bytes_out.ready) begin
        bytes_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bytes_out.out_byte     <= byte_next;
      bytes_out.last_of_run  <= last;
      bytes_out.end_of_image <= last && head.eof;
    end
  end

endmodule

// ----- rtl/core/bmp_24bit_stream_encoder_top.sv -----
// top level of the 24-bit bmp stream encoder
// a taken pixel enters the queue; its bytes then pass through the output register
// throughput: one byte per cycle while a pixel is queued and the output is not stalled;
//   a run is 3 pixel bytes, plus 0..3 pad at row end and 54 header bytes at frame start
// a two-entry queue lets pixels be taken while bytes of earlier ones drain
// reset: counters cleared, header pending, size registers 640 x 480, queue empty
module bmp_24bit_stream_encoder_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [bmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmp_pkg::DIM_W-1:0]    cfg_data,
  bmp_pixel_if.sink                    pixel_in,
  bmp_byte_if.source                   bytes_out
);

  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  bmp_pkg::cmd_t push_data;
  bmp_pkg::cmd_t head;

  bmp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (pixel_in),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  bmp_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  bmp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .bytes_out (bytes_out)
  );

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the 24-bit bmp stream encoder: directed plan, then random sizes and pixels
`timescale 1ns / 100ps

module testbench;

  localparam int HEADER_LEN    = 54;
  localparam int INFO_LEN      = 40;
  localparam int BPP           = 24;
  localparam int PELS_PER_M    = 2835;
  localparam int RANDOM_PIXELS = 455;
  localparam int PLAN_LEN      = 28;

  localparam logic [bmp_pkg::CFG_IDX_W-1:0] REG_W = bmp_pkg::REG_IMAGE_WIDTH;
  localparam logic [bmp_pkg::CFG_IDX_W-1:0] REG_H = bmp_pkg::REG_IMAGE_HEIGHT;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       eoi;
  } stream_byte_t;

  typedef enum logic {STEP_WRITE, STEP_PIXEL} step_kind_t;

  typedef struct packed {
    step_kind_t                    kind;
    logic [bmp_pkg::CFG_IDX_W-1:0] index;
    logic [bmp_pkg::DIM_W-1:0]     value;
    logic [31:0]                   pixel;
    logic [6:0]                    want_len;  // zero on register-write steps, which produce no run
    logic                          want_eoi;
  } step_t;

  logic clk = 1'b0;
  logic rst;
  logic                          cfg_wr_en;
  logic [bmp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bmp_pkg::DIM_W-1:0]     cfg_data;

  bmp_pixel_if pix_if();
  bmp_byte_if  byte_if();

  bmp_24bit_stream_encoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (pix_if),
    .bytes_out (byte_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // encoder state as the predictor sees it
  logic [bmp_pkg::DIM_W-1:0] size_w = 13'd640;
  logic [bmp_pkg::DIM_W-1:0] size_h = 13'd480;
  logic [bmp_pkg::CNT_W-1:0] col_pos = '0;
  logic [bmp_pkg::CNT_W-1:0] row_pos = '0;
  bit                        hdr_done = 1'b0;

  stream_byte_t pending_bytes[$];

  int  errors = 0;
  int  pixels_sent = 0;
  int  bytes_checked = 0;
  int  frames_closed = 0;
  int  reg_writes = 0;
  bit  steady = 1'b0;

  step_t plan [PLAN_LEN] = '{
    '{STEP_PIXEL, REG_W, 13'd0,    32'hFFFF_FFFF, 7'd57, 1'b0},  // header at reset size
    '{STEP_PIXEL, REG_W, 13'd0,    32'h0000_0000, 7'd3,  1'b0},
    '{STEP_PIXEL, REG_W, 13'd0,    32'hA55A_3CC3, 7'd3,  1'b0},  // top byte dropped
    '{STEP_WRITE, REG_W, 13'd1,    32'h0,         7'd0,  1'b0},  // column past new width
    '{STEP_PIXEL, REG_W, 13'd0,    32'h0102_0304, 7'd4,  1'b0},
    '{STEP_WRITE, REG_H, 13'd2,    32'h0,         7'd0,  1'b0},
    '{STEP_PIXEL, REG_W, 13'd0,    32'h00FF_00FF, 7'd4,  1'b1},
    '{STEP_PIXEL, REG_W, 13'd0,    32'h8000_0001, 7'd58, 1'b0},
    '{STEP_PIXEL, REG_W, 13'd0,    32'h7FFF_FFFE, 7'd4,  1'b1},
    '{STEP_WRITE, REG_W, 13'd0,    32'h0,         7'd0,  1'b0},  // zero sizes count as one
    '{STEP_WRITE, REG_H, 13'd0,    32'h0,         7'd0,  1'b0},
    '{STEP_PIXEL, REG_W, 13'd0,    32'h0055_AA55, 7'd58, 1'b1},
    '{STEP_WRITE, REG_W, 13'd4096, 32'h0,         7'd0,  1'b0},
    '{STEP_WRITE, REG_H, 13'd4096, 32'h0,         7'd0,  1'b0},
    '{STEP_PIXEL, REG_W, 13'd0,    32'hC0FF_EE00, 7'd57, 1'b0},
    '{STEP_PIXEL, REG_W, 13'd0,    32'h1234_5678, 7'd3,  1'b0},
    '{STEP_WRITE, REG_W, 13'd8191, 32'h0,         7'd0,  1'b0},  // saturates at the maximum
    '{STEP_WRITE, REG_H, 13'd8191, 32'h0,         7'd0,  1'b0},
    '{STEP_PIXEL, REG_W, 13'd0,    32'hFEDC_BA98, 7'd3,  1'b0},
    '{STEP_WRITE, REG_W, 13'd2,    32'h0,         7'd0,  1'b0},
    '{STEP_PIXEL, REG_W, 13'd0,    32'h0F0F_0F0F, 7'd5,  1'b0},
    '{STEP_WRITE, REG_H, 13'd1,    32'h0,         7'd0,  1'b0},  // row past new height
    '{STEP_PIXEL, REG_W, 13'd0,    32'hF0F0_F0F0, 7'd3,  1'b0},
    '{STEP_PIXEL, REG_W, 13'd0,    32'h3333_3333, 7'd5,  1'b1},
    '{STEP_WRITE, REG_W, 13'd3,    32'h0,         7'd0,  1'b0},
    '{STEP_PIXEL, REG_W, 13'd0,    32'h6666_6666, 7'd57, 1'b0},
    '{STEP_PIXEL, REG_W, 13'd0,    32'h9999_9999, 7'd3,  1'b0},
    '{STEP_PIXEL, REG_W, 13'd0,    32'hCCCC_CCCC, 7'd6,  1'b1}
  };

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 30)
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
  endtask

  function automatic logic [bmp_pkg::DIM_W-1:0] clamp_size(input logic [bmp_pkg::DIM_W-1:0] v,
                                                           input int max_v);
    if (v == 0)
      return bmp_pkg::DIM_W'(1);
    if (int'(v) > max_v)
      return bmp_pkg::DIM_W'(max_v);
    return v;
  endfunction

  function automatic void push_le(ref logic [7:0] q[$], input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++)
      q.push_back(v[8*i +: 8]);
  endfunction

  // bytes one pixel produces; advances the predicted counters
  function automatic int encode_pixel(input logic [31:0] pw, output bit frame_end);
    logic [bmp_pkg::DIM_W-1:0] w;
    logic [bmp_pkg::DIM_W-1:0] h;
    int                        row_len;
    int                        pad;
    logic [31:0]               img;
    logic [7:0]                run[$];
    stream_byte_t              sb;
    w = clamp_size(size_w, bmp_pkg::MAX_WIDTH);
    h = clamp_size(size_h, bmp_pkg::MAX_HEIGHT);
    row_len = 3 * int'(w);
    pad = (4 - row_len % 4) % 4;
    frame_end = 1'b0;
    if (!hdr_done) begin
      img = 32'((row_len + pad) * int'(h));
      run.push_back(8'h42);
      run.push_back(8'h4d);
      push_le(run, img + HEADER_LEN, 4);
      push_le(run, 0, 4);
      push_le(run, HEADER_LEN, 4);
      push_le(run, INFO_LEN, 4);
      push_le(run, 32'(w), 4);
      push_le(run, 32'(h), 4);
      push_le(run, 1, 2);
      push_le(run, BPP, 2);
      push_le(run, 0, 4);
      push_le(run, img, 4);
      push_le(run, PELS_PER_M, 4);
      push_le(run, PELS_PER_M, 4);
      push_le(run, 0, 8);
      hdr_done = 1'b1;
    end
    run.push_back(pw[7:0]);
    run.push_back(pw[15:8]);
    run.push_back(pw[23:16]);
    if (int'(col_pos) + 1 >= int'(w)) begin
      repeat (pad) run.push_back(8'h00);
      col_pos = '0;
      if (int'(row_pos) + 1 >= int'(h)) begin
        row_pos = '0;
        hdr_done = 1'b0;
        frame_end = 1'b1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    foreach (run[k]) begin
      sb.data = run[k];
      sb.last = (k == run.size() - 1);
      sb.eoi  = sb.last && frame_end;
      pending_bytes.push_back(sb);
    end
    return run.size();
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_pixel(input logic [31:0] pw, output int nbytes, output bit frame_end);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid      <= 1'b1;
    pix_if.pixel_word <= pw;
    do @(posedge clk); while (!pix_if.ready);
    nbytes = encode_pixel(pw, frame_end);
    pixels_sent++;
  endtask

  // sender holds off until every predicted byte has been seen
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  task automatic write_reg(input logic [bmp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bmp_pkg::DIM_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_W)
      size_w = val;
    else
      size_h = val;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic take_byte();
    stream_byte_t want;
    if (pending_bytes.size() == 0) begin
      report("byte with nothing pending", byte_if.out_byte, -1);
      return;
    end
    want = pending_bytes.pop_front();
    if (byte_if.out_byte !== want.data)
      report($sformatf("byte %0d data", bytes_checked), byte_if.out_byte, want.data);
    if (byte_if.last_of_run !== want.last)
      report($sformatf("byte %0d last_of_run", bytes_checked), byte_if.last_of_run, want.last);
    if (byte_if.end_of_image !== want.eoi)
      report($sformatf("byte %0d end_of_image", bytes_checked), byte_if.end_of_image, want.eoi);
    if (want.eoi)
      frames_closed++;
    bytes_checked++;
  endtask

  initial begin : byte_sink
    int hold;
    int r;
    byte_if.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && byte_if.valid && byte_if.ready)
        take_byte();
      if (rst) begin
        byte_if.ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
      end else if (steady) begin
        byte_if.ready <= 1'b1;
        hold = 4;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          byte_if.ready <= 1'b1;
          hold = $urandom_range(1, 10);
        end else if (r < 95) begin
          byte_if.ready <= 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          byte_if.ready <= 1'b0;
          hold = $urandom_range(15, 50);
        end
      end
    end
  end

  initial begin : stimulus
    int                        nbytes;
    bit                        frame_end;
    int                        choice;
    int                        npix;
    int                        random_sent;
    logic [bmp_pkg::DIM_W-1:0] w;
    logic [bmp_pkg::DIM_W-1:0] h;
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= REG_W;
    cfg_data          <= '0;
    pix_if.valid      <= 1'b0;
    pix_if.pixel_word <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].kind == STEP_WRITE) begin
        wait_drained();
        write_reg(plan[k].index, plan[k].value);
      end else begin
        send_pixel(plan[k].pixel, nbytes, frame_end);
        if (nbytes != plan[k].want_len || frame_end != plan[k].want_eoi)
          report($sformatf("directed row %0d run length", k), nbytes, plan[k].want_len);
      end
    end

    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      wait_drained();
      steady = ($urandom_range(0, 5) == 0);
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
        // any register value, frame left open for the next phase to cut short
        write_reg(REG_W, bmp_pkg::DIM_W'($urandom()));
        write_reg(REG_H, bmp_pkg::DIM_W'($urandom()));
        npix = $urandom_range(1, 4);
      end else if (choice == 1) begin
        write_reg($urandom_range(0, 1) ? REG_H : REG_W,
                  bmp_pkg::DIM_W'($urandom_range(0, 6)));
        npix = $urandom_range(1, 12);
      end else begin
        w = bmp_pkg::DIM_W'($urandom_range(1, 9));
        h = bmp_pkg::DIM_W'($urandom_range(1, 4));
        write_reg(REG_W, w);
        write_reg(REG_H, h);
        npix = int'(w) * int'(h) * $urandom_range(1, 2);
      end
      repeat (npix) begin
        send_pixel($urandom(), nbytes, frame_end);
        random_sent++;
      end
    end

    steady = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d pixels over %0d size writes, incl. zero, saturated and mid-frame sizes",
             pixels_sent, reg_writes);
    $display("checked %0d output bytes, %0d frames closed", bytes_checked, frames_closed);
    if (errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("timeout with %0d bytes still pending", pending_bytes.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bmp_pkg.sv
rtl/core/bmp_stream_if.sv
rtl/core/bmp_front.sv
rtl/core/bmp_cmd_fifo.sv
rtl/core/bmp_back.sv
rtl/core/bmp_24bit_stream_encoder_top.sv
tb/testbench.sv
